// ----- rtl/fsd_pkg.sv -----
// ----------------------------------------------------------------------------
// Fibonacci sphere direction generator package
// Widths, gain, golden-angle step and arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package fsd_pkg;

    localparam int FRAC_BITS_DEF     = 15;
    localparam int INDEX_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int POINTS_W   = 16;
    localparam int GUARD_BITS = 16;

    localparam logic [15:0] POINTS_RESET = 16'd1000;
    localparam logic [31:0] GOLDEN_TURN  = 32'd1640531527;
    localparam logic [31:0] GAIN_Q32     = 32'd2608131496;

    typedef logic [POINTS_W-1:0] points_t;

    function automatic logic [31:0] atan_turn(input int k);
        logic [31:0] r;
        case (k)
            0: r = 32'd536870912;  1: r = 32'd316933406;  2: r = 32'd167458907;
            3: r = 32'd85004756;   4: r = 32'd42667331;   5: r = 32'd21354465;
            6: r = 32'd10679838;   7: r = 32'd5340245;    8: r = 32'd2670163;
            9: r = 32'd1335087;    10: r = 32'd667544;    11: r = 32'd333772;
            12: r = 32'd166886;    13: r = 32'd83443;     14: r = 32'd41722;
            15: r = 32'd20861;     16: r = 32'd10430;     17: r = 32'd5215;
            18: r = 32'd2608;      19: r = 32'd1304;      20: r = 32'd652;
            21: r = 32'd326;       22: r = 32'd163;       23: r = 32'd81;
            24: r = 32'd41;        25: r = 32'd20;        26: r = 32'd10;
            27: r = 32'd5;         28: r = 32'd3;         29: r = 32'd1;
            30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fsd_recip.sv -----
// ----------------------------------------------------------------------------
// Reciprocal of N-1
// Restoring divider forming round(2^(F+I)/(N-1)) one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fsd_recip #(
    parameter int FRAC_BITS  = fsd_pkg::FRAC_BITS_DEF,
    parameter int INDEX_BITS = fsd_pkg::INDEX_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire fsd_pkg::points_t          divisor_n,
    output logic                           busy,
    output logic [FRAC_BITS+INDEX_BITS:0]  recip
);
    import fsd_pkg::*;

    localparam int QW = FRAC_BITS + INDEX_BITS + 1;
    localparam int CW = $clog2(QW + 1);
    localparam int RW = POINTS_W + 1;

    logic [QW-1:0]          num_reg;
    logic [QW-1:0]          quo_reg;
    logic [RW-1:0]          rem_reg;
    logic [POINTS_W-1:0]    den_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   busy_reg;
    logic [QW-1:0]          recip_reg;
    logic [RW-1:0]          trial;
    logic [RW-1:0]          rem_next;
    logic [QW-1:0]          quo_next;
    logic                   ge;

    always_comb begin
        trial    = {rem_reg[RW-2:0], num_reg[QW-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? trial - {1'b0, den_reg} : trial;
        quo_next = {quo_reg[QW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            // reset value N = 1000 is loaded by a start pulse from the top
            recip_reg <= '0;
        end else if (start) begin
            num_reg <= (QW'(1) << (QW-1)) + QW'((divisor_n - 16'd1) >> 1);
            quo_reg <= '0;
            rem_reg <= '0;
            den_reg <= divisor_n - 16'd1;
            cnt_reg <= CW'(QW);
            busy_reg <= divisor_n > 16'd1;
            if (divisor_n <= 16'd1) begin
                recip_reg <= '0;
            end
        end else if (busy_reg) begin
            num_reg <= {num_reg[QW-2:0], 1'b0};
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_reg  <= 1'b0;
                recip_reg <= quo_next;
            end
        end
    end

    assign busy  = busy_reg;
    assign recip = recip_reg;

endmodule

`default_nettype wire

// ----- rtl/fsd_cordic.sv -----
// ----------------------------------------------------------------------------
// CORDIC rotation pipeline
// One micro-rotation per stage, with valid and quadrant carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module fsd_cordic #(
    parameter int FRAC_BITS     = fsd_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = fsd_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic signed [FRAC_BITS+17:0]   in_x,
    input  wire logic signed [31:0]             in_ang,
    input  wire logic [1:0]                     in_quad,
    input  wire logic signed [FRAC_BITS+1:0]    in_z,
    input  wire logic                           in_flag,
    output logic                                out_valid,
    output logic signed [FRAC_BITS+17:0]        out_x,
    output logic signed [FRAC_BITS+17:0]        out_y,
    output logic [1:0]                          out_quad,
    output logic signed [FRAC_BITS+1:0]         out_z,
    output logic                                out_flag
);
    import fsd_pkg::*;

    localparam int XW = FRAC_BITS + 18;
    localparam int N  = CORDIC_STAGES;

    logic                       v_reg   [N+1];
    logic signed [XW-1:0]       x_reg   [N+1];
    logic signed [XW-1:0]       y_reg   [N+1];
    logic signed [31:0]         a_reg   [N+1];
    logic [1:0]                 q_reg   [N+1];
    logic signed [FRAC_BITS+1:0] z_reg  [N+1];
    logic                       f_reg   [N+1];

    always_comb begin
        v_reg[0] = in_valid;
        x_reg[0] = in_x;
        y_reg[0] = '0;
        a_reg[0] = in_ang;
        q_reg[0] = in_quad;
        z_reg[0] = in_z;
        f_reg[0] = in_flag;
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic signed [XW-1:0] dx, dy;
        logic signed [31:0]   at;
        assign dx = x_reg[k] >>> ((k < XW) ? k : XW - 1);
        assign dy = y_reg[k] >>> ((k < XW) ? k : XW - 1);
        assign at = atan_turn(k);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
            if (en) begin
                if (!a_reg[k][31]) begin
                    x_reg[k+1] <= x_reg[k] - dy;
                    y_reg[k+1] <= y_reg[k] + dx;
                    a_reg[k+1] <= a_reg[k] - at;
                end else begin
                    x_reg[k+1] <= x_reg[k] + dy;
                    y_reg[k+1] <= y_reg[k] - dx;
                    a_reg[k+1] <= a_reg[k] + at;
                end
                q_reg[k+1] <= q_reg[k];
                z_reg[k+1] <= z_reg[k];
                f_reg[k+1] <= f_reg[k];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_x     = x_reg[N];
    assign out_y     = y_reg[N];
    assign out_quad  = q_reg[N];
    assign out_z     = z_reg[N];
    assign out_flag  = f_reg[N];

endmodule

`default_nettype wire

// ----- rtl/fibonacci_sphere_direction_gen.sv -----
// ----------------------------------------------------------------------------
// Fibonacci sphere direction generator
// Unit direction of point i on a golden-angle sphere, Q1.FRAC_BITS.
// ----------------------------------------------------------------------------
// Usage: write the point count through cfg_we/cfg_wdata while the block is
// idle; the reciprocal of N-1 is then formed by a bit-serial divider, after
// reset as well. s_ready stays low in the write cycle and while the divider
// runs. Send ray indices on s_valid/s_ready; results leave on m_valid/m_ready
// as dir_x, dir_y, dir_z and index_clamped.
// Throughput: one beat per cycle while the receiver keeps up and the divider
// is idle. Pipeline stages in order: clamp, multiply, round, square, root in
// four quarters, gain, one CORDIC micro-rotation per stage, output register.
// The whole pipeline advances together: when m_ready is low and a result is
// waiting, every stage holds and s_ready drops; nothing is lost or repeated.
// Reset clears all valid bits and reloads N = 1000.
// ----------------------------------------------------------------------------
`default_nettype none

module fibonacci_sphere_direction_gen #(
    parameter int FRAC_BITS     = fsd_pkg::FRAC_BITS_DEF,
    parameter int INDEX_BITS    = fsd_pkg::INDEX_BITS_DEF,
    parameter int CORDIC_STAGES = fsd_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [15:0]            cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [15:0]            s_ray_index,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [FRAC_BITS+1:0]        m_dir_x,
    output logic [FRAC_BITS+1:0]        m_dir_y,
    output logic [FRAC_BITS+1:0]        m_dir_z,
    output logic                        m_index_clamped
);
    import fsd_pkg::*;

    localparam int S   = 1 << FRAC_BITS;
    localparam int RW  = FRAC_BITS + INDEX_BITS + 1;
    localparam int XW  = FRAC_BITS + 18;
    localparam int ZW  = FRAC_BITS + 2;
    localparam int MW  = 2 * FRAC_BITS + 2;
    localparam int RTW = FRAC_BITS + 1;

    // config and reciprocal
    points_t           n_reg;
    logic              init_reg;
    logic              div_start;
    logic              div_busy;
    logic              en;
    logic [RW-1:0]     recip;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg    <= POINTS_RESET;
            init_reg <= 1'b1;
        end else begin
            init_reg <= 1'b0;
            if (cfg_we) begin
                n_reg <= (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
            end
        end
    end

    assign div_start = init_reg || cfg_we;

    fsd_recip #(.FRAC_BITS(FRAC_BITS), .INDEX_BITS(INDEX_BITS)) u_recip (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .divisor_n((cfg_we && aresetn) ? ((cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata)
                                       : POINTS_RESET),
        .busy(div_busy),
        .recip(recip)
    );

    assign en      = !m_valid || m_ready;
    // hold input off until the reciprocal of the current count is ready
    assign s_ready = en && !div_busy && !init_reg && !cfg_we;

    // stage 1: clamp, phase
    logic                  v1_reg, f1_reg;
    logic [INDEX_BITS-1:0] i1_reg;
    logic [31:0]           ph1_reg;
    logic [INDEX_BITS-1:0] im;
    logic                  over;
    always_comb begin
        im   = INDEX_BITS'(s_ray_index);
        over = {{(32-INDEX_BITS){1'b0}}, im} >= {16'd0, n_reg};
        if (over) im = INDEX_BITS'(n_reg - 16'd1);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en) v1_reg <= s_valid && s_ready;
        if (en) begin
            i1_reg  <= im;
            f1_reg  <= over;
            ph1_reg <= 32'(im * GOLDEN_TURN);
        end
    end

    // stage 2: i*recip
    logic                      v2_reg, f2_reg;
    logic [RW+INDEX_BITS-1:0]  p2_reg;
    logic [31:0]               ph2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1_reg;
        if (en) begin
            p2_reg  <= (RW+INDEX_BITS)'(i1_reg) * (RW+INDEX_BITS)'(recip);
            f2_reg  <= f1_reg;
            ph2_reg <= ph1_reg;
        end
    end

    // stage 3: round, limit, z
    logic                  v3_reg, f3_reg;
    logic signed [ZW-1:0]  z3_reg;
    logic [31:0]           ph3_reg;
    logic [RW+INDEX_BITS-1:0] tr;
    always_comb begin
        tr = (p2_reg + ((RW+INDEX_BITS)'(1) << (INDEX_BITS-1))) >> INDEX_BITS;
        if (tr > (RW+INDEX_BITS)'(2*S)) tr = (RW+INDEX_BITS)'(2*S);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en) v3_reg <= v2_reg;
        if (en) begin
            z3_reg  <= ZW'(S) - ZW'(tr);
            f3_reg  <= f2_reg;
            ph3_reg <= ph2_reg;
        end
    end

    // stage 4: S*S - z*z
    logic                  v4_reg, f4_reg;
    logic [MW-1:0]         m4_reg;
    logic signed [ZW-1:0]  z4_reg;
    logic [31:0]           ph4_reg;
    logic signed [2*ZW-1:0] zsq;
    assign zsq = z3_reg * z3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en) v4_reg <= v3_reg;
        if (en) begin
            m4_reg  <= MW'((2*ZW)'(S) * (2*ZW)'(S) - zsq);
            z4_reg  <= z3_reg;
            f4_reg  <= f3_reg;
            ph4_reg <= ph3_reg;
        end
    end

    // stages 5 to 8: integer square root, digit by digit, a quarter per stage
    localparam int SQS = 4;
    localparam int SQD = (RTW + SQS - 1) / SQS;
    function automatic logic [MW+RTW:0] sqrt_steps(
        input logic [MW-1:0] v, input logic [RTW-1:0] r, input logic [MW-1:0] rem,
        input int first, input int cnt);
        logic [MW-1:0] rm;
        logic [RTW-1:0] rs;
        logic [MW+1:0] acc;
        rm = rem;
        rs = r;
        for (int k = 0; k < cnt; k++) begin
            acc = {rm, v[MW-1-2*(first+k) -: 2]};
            if (acc >= {rs, 2'b01}) begin
                rm = MW'(acc - {rs, 2'b01});
                rs = {rs[RTW-2:0], 1'b1};
            end else begin
                rm = MW'(acc);
                rs = {rs[RTW-2:0], 1'b0};
            end
        end
        return {1'b0, rm, rs};
    endfunction

    logic                  sv_reg  [SQS+1];
    logic                  sf_reg  [SQS+1];
    logic [MW-1:0]         sm_reg  [SQS+1];
    logic [MW-1:0]         srm_reg [SQS+1];
    logic [RTW-1:0]        sr_reg  [SQS+1];
    logic signed [ZW-1:0]  sz_reg  [SQS+1];
    logic [31:0]           sph_reg [SQS+1];

    always_comb begin
        sv_reg[0]  = v4_reg;
        sf_reg[0]  = f4_reg;
        sm_reg[0]  = m4_reg;
        srm_reg[0] = '0;
        sr_reg[0]  = '0;
        sz_reg[0]  = z4_reg;
        sph_reg[0] = ph4_reg;
    end

    for (genvar s = 0; s < SQS; s++) begin : g_root
        localparam int FIRST = s * SQD;
        localparam int CNT   = (RTW - FIRST >= SQD) ? SQD :
                               ((RTW > FIRST) ? RTW - FIRST : 0);
        logic [MW+RTW:0] root_step;
        assign root_step = sqrt_steps(sm_reg[s], sr_reg[s], srm_reg[s], FIRST, CNT);
        always_ff @(posedge aclk) begin
            if (!aresetn) sv_reg[s+1] <= 1'b0;
            else if (en) sv_reg[s+1] <= sv_reg[s];
            if (en) begin
                sm_reg[s+1]  <= sm_reg[s];
                srm_reg[s+1] <= root_step[MW+RTW-1:RTW];
                sr_reg[s+1]  <= root_step[RTW-1:0];
                sz_reg[s+1]  <= sz_reg[s];
                sf_reg[s+1]  <= sf_reg[s];
                sph_reg[s+1] <= sph_reg[s];
            end
        end
    end

    // stage 9: gain, quadrant split
    logic                  v7_reg, f7_reg;
    logic signed [XW-1:0]  x7_reg;
    logic signed [31:0]    a7_reg;
    logic [1:0]            q7_reg;
    logic signed [ZW-1:0]  z7_reg;
    logic [32:0]           phr;
    logic [RTW+31:0]       gp;
    assign phr = {1'b0, sph_reg[SQS]} + 33'(1 << 29);
    assign gp  = (RTW+32)'(sr_reg[SQS]) * (RTW+32)'(GAIN_Q32);
    always_ff @(posedge aclk) begin
        if (!aresetn) v7_reg <= 1'b0;
        else if (en) v7_reg <= sv_reg[SQS];
        if (en) begin
            x7_reg <= XW'(gp >> (32 - GUARD_BITS));
            a7_reg <= $signed({2'b00, phr[29:0]}) - 32'sd536870912;
            q7_reg <= phr[31:30];
            z7_reg <= sz_reg[SQS];
            f7_reg <= sf_reg[SQS];
        end
    end

    logic                  vc, fc;
    logic signed [XW-1:0]  xc, yc;
    logic [1:0]            qc;
    logic signed [ZW-1:0]  zc;
    fsd_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v7_reg), .in_x(x7_reg), .in_ang(a7_reg), .in_quad(q7_reg),
        .in_z(z7_reg), .in_flag(f7_reg),
        .out_valid(vc), .out_x(xc), .out_y(yc), .out_quad(qc),
        .out_z(zc), .out_flag(fc)
    );

    // output stage: round, quadrant, saturate
    logic signed [XW-1:0]  xrd, yrd, xq, yq;
    logic signed [ZW-1:0]  xs, ys;
    logic                  vo_reg, fo_reg;
    logic signed [ZW-1:0]  xo_reg, yo_reg, zo_reg;
    always_comb begin
        xrd = (xc + XW'(1 << (GUARD_BITS-1))) >>> GUARD_BITS;
        yrd = (yc + XW'(1 << (GUARD_BITS-1))) >>> GUARD_BITS;
        case (qc)
            2'd1:    begin xq = -yrd; yq = xrd;  end
            2'd2:    begin xq = -xrd; yq = -yrd; end
            2'd3:    begin xq = yrd;  yq = -xrd; end
            default: begin xq = xrd;  yq = yrd;  end
        endcase
        xs = (xq > XW'(S)) ? ZW'(S) : (xq < -XW'(S)) ? -ZW'(S) : ZW'(xq);
        ys = (yq > XW'(S)) ? ZW'(S) : (yq < -XW'(S)) ? -ZW'(S) : ZW'(yq);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) vo_reg <= 1'b0;
        else if (en) vo_reg <= vc;
        if (en) begin
            xo_reg <= xs;
            yo_reg <= ys;
            zo_reg <= zc;
            fo_reg <= fc;
        end
    end

    assign m_valid         = vo_reg;
    assign m_dir_x         = xo_reg;
    assign m_dir_y         = yo_reg;
    assign m_dir_z         = zo_reg;
    assign m_index_clamped = fo_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dir_x) && $stable(m_dir_z))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready))
        else $error("ready out of step with output stage");
    a_z_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_dir_z) <= $signed(ZW'(S)) &&
                     $signed(m_dir_z) >= -$signed(ZW'(S))))
        else $error("z out of range");

endmodule

`default_nettype wire

// ----- bench/fibonacci_sphere_direction_gen_tb.sv -----
// ----------------------------------------------------------------------------
// Fibonacci sphere direction generator testbench
// Drives ray indices in random bursts over a series of point counts, predicts
// each direction in fixed point and checks every result beat in order while
// the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
`default_nettype none

module fibonacci_sphere_direction_gen_tb;

    typedef struct packed {
        logic [16:0] dir_x;
        logic [16:0] dir_y;
        logic [16:0] dir_z;
        logic        clamped;
    } direction_t;

    localparam longint UNIT = 64'd32768;

    localparam logic [31:0] ATAN_TURN [0:15] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_ray_index;
    logic        m_valid;
    logic        m_ready;
    logic [16:0] m_dir_x;
    logic [16:0] m_dir_y;
    logic [16:0] m_dir_z;
    logic        m_index_clamped;

    logic [15:0]     pending_idx[$];
    direction_t      want_dir[$];
    int              fail_count;
    longint          point_count;
    longint          recip_q;
    int              burst_left;
    int              gap_left;
    int              ready_pct;
    int              ready_timer;

    fibonacci_sphere_direction_gen u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ray_index     (s_ray_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_dir_x         (m_dir_x),
        .m_dir_y         (m_dir_y),
        .m_dir_z         (m_dir_z),
        .m_index_clamped (m_index_clamped)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void load_count(input logic [15:0] value);
        longint n;
        n = value;
        if (n == 0) n = 1;
        point_count = n;
        recip_q = (n <= 1) ? 0 : ((64'd1 << 31) + (n - 1) / 2) / (n - 1);
    endfunction

    function automatic longint floor_sqrt(input longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'd1 << 40;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clip_unit(input longint v);
        if (v > UNIT) return UNIT;
        if (v < -UNIT) return -UNIT;
        return v;
    endfunction

    function automatic direction_t sphere_point(input logic [15:0] idx);
        direction_t d;
        longint i, t, z, rad, x, y, ang, dx, dy, xr, yr, sum;
        logic [31:0] phase;
        logic [1:0]  quad;
        i = idx;
        d.clamped = 1'b0;
        if (i >= point_count) begin
            i = point_count - 1;
            d.clamped = 1'b1;
        end
        t = (i * recip_q + 32768) >> 16;
        if (t > 2 * UNIT) t = 2 * UNIT;
        z = UNIT - t;
        rad = floor_sqrt(UNIT * UNIT - z * z);
        sum = i * 64'd1640531527;
        phase = sum[31:0];
        sum = longint'(phase) + (64'd1 << 29);
        quad = sum[31:30];
        ang = (sum & ((64'd1 << 30) - 1)) - (64'd1 << 29);
        x = (rad * 64'd2608131496) >> 16;
        y = 0;
        for (int k = 0; k < 16; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (ang >= 0) begin
                x = x - dx;
                y = y + dy;
                ang = ang - ATAN_TURN[k];
            end else begin
                x = x + dx;
                y = y - dy;
                ang = ang + ATAN_TURN[k];
            end
        end
        x = (x + 32768) >>> 16;
        y = (y + 32768) >>> 16;
        case (quad)
            2'd1: begin xr = -y; yr = x; end
            2'd2: begin xr = -x; yr = -y; end
            2'd3: begin xr = y; yr = -x; end
            default: begin xr = x; yr = y; end
        endcase
        xr = clip_unit(xr);
        yr = clip_unit(yr);
        d.dir_x = xr[16:0];
        d.dir_y = yr[16:0];
        d.dir_z = z[16:0];
        return d;
    endfunction

    // Sender: bursts of random length, random gaps, hold a beat until taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_ray_index <= '0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else begin
            if (s_valid && s_ready)
                want_dir = {want_dir, sphere_point(s_ray_index)};
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_idx.size() > 0) begin
                    s_valid     <= 1'b1;
                    s_ray_index <= pending_idx.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall rate changes every so often, with spells of no stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            ready_pct   <= 100;
            ready_timer <= 0;
        end else begin
            if (ready_timer == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pct <= 100;
                    1: ready_pct <= 75;
                    2: ready_pct <= 40;
                    default: ready_pct <= 10;
                endcase
                ready_timer <= $urandom_range(20, 300);
            end else begin
                ready_timer <= ready_timer - 1;
            end
            m_ready <= ($urandom_range(0, 99) < ready_pct);
            if (m_valid && m_ready) begin
                if (want_dir.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    fail_count = fail_count + 1;
                end else begin
                    direction_t w;
                    w = want_dir.pop_front();
                    if (w.dir_x !== m_dir_x) begin
                        $display("%0t: dir_x expected %0d got %0d", $time,
                                 $signed(w.dir_x), $signed(m_dir_x));
                        fail_count = fail_count + 1;
                    end
                    if (w.dir_y !== m_dir_y) begin
                        $display("%0t: dir_y expected %0d got %0d", $time,
                                 $signed(w.dir_y), $signed(m_dir_y));
                        fail_count = fail_count + 1;
                    end
                    if (w.dir_z !== m_dir_z) begin
                        $display("%0t: dir_z expected %0d got %0d", $time,
                                 $signed(w.dir_z), $signed(m_dir_z));
                        fail_count = fail_count + 1;
                    end
                    if (w.clamped !== m_index_clamped) begin
                        $display("%0t: index_clamped expected %0b got %0b", $time,
                                 w.clamped, m_index_clamped);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

    task automatic queue_index(input logic [15:0] idx);
        pending_idx = {pending_idx, idx};
    endtask

    task automatic drain();
        while (pending_idx.size() != 0 || s_valid || want_dir.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_count(input logic [15:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        load_count(value);
    endtask

    task automatic queue_edges();
        logic [15:0] n;
        n = point_count[15:0];
        queue_index(16'd0);
        queue_index(n - 16'd1);
        queue_index(n);
        queue_index(16'hFFFF);
        queue_index(16'd1);
    endtask

    task automatic queue_random(input int count);
        for (int j = 0; j < count; j++) begin
            if ($urandom_range(0, 9) == 0)
                queue_index(16'($urandom_range(0, 65535)));
            else
                queue_index(16'($urandom_range(0, point_count - 1)));
        end
    endtask

    initial begin
        logic [15:0] counts [0:9];
        counts = '{16'd1, 16'd0, 16'd65535, 16'd2, 16'd3, 16'd4096,
                   16'd37, 16'd65534, 16'd777, 16'd1000};
        fail_count  = 0;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        m_ready     = 1'b0;
        s_valid     = 1'b0;
        s_ray_index = '0;
        load_count(16'd1000);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset count, directed corners then a mix
        queue_edges();
        queue_index(16'd500);
        queue_index(16'd999);
        queue_index(16'hAAAA);
        queue_index(16'h5555);
        queue_random(20);
        for (int p = 0; p < 10; p++) begin
            write_count(counts[p]);
            queue_edges();
            queue_random((counts[p] == 16'd65535) ? 200 : 100);
            if (p == 2) begin
                // hold the sender until the pipe is empty, then resume
                drain();
                queue_random(100);
            end
        end
        drain();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
